// ----- hdl/cfdl_pkg.sv -----
// Shared types and constants for the crossfading delay line.
// Request and result payload structs, operation codes and weight constants.
// No dependencies.
package cfdl_pkg;

    // Operation codes carried in a request
    localparam logic OP_PUSH      = 1'b0;
    localparam logic OP_SET_DELAY = 1'b1;

    // Q1.15 weight of one and the reset value of the fade step
    localparam logic [15:0] WEIGHT_ONE = 16'd32768;
    localparam logic [15:0] STEP_RESET = 16'd32;

    // Rounding offset for the Q1.15 mix
    localparam int unsigned ROUND_HALF = 16384;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] sample_in;
        logic [15:0]        delay_samples;
    } in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               crossfading;
    } out_t;

endpackage

// ----- hdl/crossfading_delay_line.sv -----
// Crossfading variable delay line, top level.
// Uses cfdl_pkg for the request/result structs, operation codes and constants.
//
// Usage:
//   Requests arrive on in_valid / in_stall / in_data. A push request writes
//   sample_in into the ring store and yields one result on out_valid /
//   out_stall / out_data: the crossfade of the current and target delay taps
//   read before the write. A set-delay request clamps delay_samples to
//   DEPTH-1, starts a crossfade and yields no result.
//   cfg_we / cfg_wdata write the Q1.15 fade step; write only while idle.
// Throughput and pipeline:
//   One request per cycle, sustained, while in_stall is low. A push result passes
//   through the input register and then the result register after its request is
//   taken: the store read fills the input register, then weighting, sum and
//   saturation run in one pass into the result register. The rate is set by the
//   store, which serves two reads and one write in every cycle.
// Reset and stalls:
//   rst_n clears all control state at once and the step returns to 32. The
//   store needs no clearing pass: a fill count marks entries never written,
//   and those read as zero. When out_stall is high the result holds, the
//   input register behind it keeps filling, and in_stall rises once both
//   are full.
module crossfading_delay_line #(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cfdl_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cfdl_pkg::out_t    out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    // Ring store
    logic signed [15:0] store_mem [DEPTH];

    // Control state
    logic [AW-1:0] wp_reg,        wp_next;
    logic [FW-1:0] fill_reg,      fill_next;
    logic [AW-1:0] cur_delay_reg, cur_delay_next;
    logic [AW-1:0] tgt_delay_reg, tgt_delay_next;
    logic [15:0]   old_w_reg,     old_w_next;
    logic [15:0]   new_w_reg,     new_w_next;
    logic          fade_reg,      fade_next;
    logic [15:0]   step_reg;

    // Pipeline valids
    logic s1_valid_reg, out_valid_reg;

    // Stage 1 payload: tap data and the weights it is mixed with
    logic signed [15:0] s1_cur_reg, s1_new_reg;
    logic               s1_cur_ok_reg, s1_new_ok_reg;
    logic [15:0]        s1_old_w_reg, s1_new_w_reg;
    logic               s1_fade_reg;

    cfdl_pkg::out_t out_data_reg;

    // Handshake and flow
    logic out_free, s1_free;
    logic in_accept, push, set_delay, out_load;

    // Datapath signals
    logic [AW-1:0]      tap_cur, tap_new;
    logic               cur_ok, new_ok;
    logic [AW-1:0]      clamped_delay;
    logic [16:0]        new_w_sum;
    logic [15:0]        old_w_dec;
    logic               fade_done;
    logic               fade_after;
    logic signed [15:0] cur_masked, new_masked;
    logic signed [32:0] prod_cur, prod_new;
    logic signed [33:0] mix_acc, mix_q;
    logic signed [15:0] mix_sat;

    // Ring position of the entry that lies delay samples behind the newest one
    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                               input logic [AW-1:0] delay);
        logic [AW:0] sum;
        begin
            sum = {1'b0, wp} + (AW+1)'(DEPTH - 1) - {1'b0, delay};
            if (sum >= (AW+1)'(DEPTH))
            begin
                sum = sum - (AW+1)'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    // Flow: each stage moves when the one after it has room
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;
    assign push      = in_accept && (in_data.operation == cfdl_pkg::OP_PUSH);
    assign set_delay = in_accept && (in_data.operation == cfdl_pkg::OP_SET_DELAY);
    assign out_load  = s1_valid_reg && out_free;

    // Tap addresses and whether those entries were ever written
    assign tap_cur = tap_addr(wp_reg, cur_delay_reg);
    assign tap_new = tap_addr(wp_reg, tgt_delay_reg);
    assign cur_ok  = FW'(tap_cur) < fill_reg;
    assign new_ok  = FW'(tap_new) < fill_reg;

    // Clamp the requested delay to the oldest entry
    always_comb
    begin
        if ({1'b0, in_data.delay_samples} > 17'(DEPTH - 1))
        begin
            clamped_delay = AW'(DEPTH - 1);
        end
        else
        begin
            clamped_delay = in_data.delay_samples[AW-1:0];
        end
    end

    // Advance the crossfade weights by one step
    assign new_w_sum  = {1'b0, new_w_reg} + {1'b0, step_reg};
    assign old_w_dec  = (old_w_reg > step_reg) ? (old_w_reg - step_reg) : 16'd0;
    assign fade_done  = new_w_sum >= {1'b0, cfdl_pkg::WEIGHT_ONE};
    assign fade_after = fade_reg && !fade_done;

    // Next control state
    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        cur_delay_next = cur_delay_reg;
        tgt_delay_next = tgt_delay_reg;
        old_w_next     = old_w_reg;
        new_w_next     = new_w_reg;
        fade_next      = fade_reg;
        if (set_delay)
        begin
            tgt_delay_next = clamped_delay;
            fade_next      = 1'b1;
        end
        else if (push)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != FW'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (fade_reg)
            begin
                if (fade_done)
                begin
                    old_w_next     = cfdl_pkg::WEIGHT_ONE;
                    new_w_next     = 16'd0;
                    cur_delay_next = tgt_delay_reg;
                    fade_next      = 1'b0;
                end
                else
                begin
                    old_w_next = old_w_dec;
                    new_w_next = new_w_sum[15:0];
                end
            end
        end
    end

    // Hold control state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            cur_delay_reg <= '0;
            tgt_delay_reg <= '0;
            old_w_reg     <= cfdl_pkg::WEIGHT_ONE;
            new_w_reg     <= 16'd0;
            fade_reg      <= 1'b0;
            step_reg      <= cfdl_pkg::STEP_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            cur_delay_reg <= cur_delay_next;
            tgt_delay_reg <= tgt_delay_next;
            old_w_reg     <= old_w_next;
            new_w_reg     <= new_w_next;
            fade_reg      <= fade_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (s1_free)
            begin
                s1_valid_reg <= push;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read both taps before the write of the same push, then store the sample
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_cur_reg        <= store_mem[tap_cur];
            s1_new_reg        <= store_mem[tap_new];
            store_mem[wp_reg] <= in_data.sample_in;
        end
    end

    // Stage 1 side payload: weights in force before this push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_cur_ok_reg <= cur_ok;
            s1_new_ok_reg <= new_ok;
            s1_old_w_reg  <= old_w_reg;
            s1_new_w_reg  <= new_w_reg;
            s1_fade_reg   <= fade_after;
        end
    end

    // Weight the taps; unwritten entries count as silence
    assign cur_masked = s1_cur_ok_reg ? s1_cur_reg : 16'sd0;
    assign new_masked = s1_new_ok_reg ? s1_new_reg : 16'sd0;
    assign prod_cur   = $signed({1'b0, s1_old_w_reg}) * cur_masked;
    assign prod_new   = $signed({1'b0, s1_new_w_reg}) * new_masked;

    // Sum, round half up, drop the fraction and saturate
    assign mix_acc = {prod_cur[32], prod_cur}
                   + {prod_new[32], prod_new}
                   + 34'(cfdl_pkg::ROUND_HALF);
    assign mix_q   = mix_acc >>> 15;

    always_comb
    begin
        priority if (mix_q > 34'sd32767)
        begin
            mix_sat = 16'sd32767;
        end
        else if (mix_q < -34'sd32768)
        begin
            mix_sat = -16'sd32768;
        end
        else
        begin
            mix_sat = mix_q[15:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.sample_out  <= mix_sat;
            out_data_reg.crossfading <= s1_fade_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // With no fade running the weights rest at one and zero
    a_idle_weights: assert property (@(posedge clk) disable iff (!rst_n)
        !fade_reg |-> (old_w_reg == cfdl_pkg::WEIGHT_ONE) && (new_w_reg == 16'd0))
        else $error("weights not at rest outside a crossfade");

    // Until the store is full the write position tracks the fill count
    a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FW'(DEPTH)) |-> (wp_reg == fill_reg[AW-1:0]))
        else $error("fill count and write position disagree");

    // A taken push always lands in stage 1
    a_push_enters: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> s1_valid_reg)
        else $error("accepted push lost before stage 1");

endmodule
